// File: rtl/core/dsd_pkg.sv
// shared types and constants for the differential symbol descrambler
package dsd_pkg;

	localparam int SYM_W   = 4;
	localparam int QUAD_W  = 2;
	localparam int TAP_W   = 5;
	localparam int HIST_W  = 32;
	localparam int RUN_W   = 7;
	localparam int BITS_W  = 4;
	localparam int COUNT_W = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	// run of raw ones after which the next output bit is inverted
	localparam logic [RUN_W-1:0] RUN_LIMIT = 7'd64;

	localparam logic [TAP_W-1:0] FIRST_TAP_RST  = 5'd14;
	localparam logic [TAP_W-1:0] SECOND_TAP_RST = 5'd17;

	localparam logic [COUNT_W-1:0] COUNT_TWO  = 3'd2;
	localparam logic [COUNT_W-1:0] COUNT_FOUR = 3'd4;

	// register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_TAP  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_TAP = 1'b1;

	// quadrant change to dibit
	localparam logic [QUAD_W-1:0] QUAD_MAP [4] = '{2'd1, 2'd0, 2'd2, 2'd3};

	// raw bits in decode order, first bit in bit 3
	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic              four;
	} raw_t;

endpackage

// File: rtl/core/dsd_decode.sv
// differential quadrant decode into raw bits
module dsd_decode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      advance,
	input  logic [dsd_pkg::SYM_W-1:0] symbol_index,
	input  logic                      sixteen_point,
	output dsd_pkg::raw_t             raw
);
	import dsd_pkg::*;

	logic [QUAD_W-1:0] prev_quad_q;
	logic [QUAD_W-1:0] quad;
	logic [QUAD_W-1:0] delta;

	assign quad  = symbol_index[3:2];
	assign delta = quad - prev_quad_q;

	always_comb begin
		raw.bits = {QUAD_MAP[delta], symbol_index[1:0]};
		raw.four = sixteen_point;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_quad_q <= '0;
		end else if (advance) begin
			prev_quad_q <= quad;
		end
	end

endmodule

// File: rtl/core/dsd_descrambler.sv
// self-synchronizing descrambler, up to four bits per cycle while advance is high
module dsd_descrambler (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [dsd_pkg::TAP_W-1:0]   first_tap,
	input  logic [dsd_pkg::TAP_W-1:0]   second_tap,
	input  dsd_pkg::raw_t               raw,
	output logic [dsd_pkg::BITS_W-1:0]  data_bits
);
	import dsd_pkg::*;

	logic [HIST_W-1:0] hist_q;
	logic [RUN_W-1:0]  run_q;
	logic [HIST_W-1:0] hist_d;
	logic [RUN_W-1:0]  run_d;
	logic [BITS_W-1:0] descr;

	always_comb begin
		logic [HIST_W-1:0] h;
		logic [RUN_W-1:0]  r;
		logic              b;
		logic              o;
		h     = hist_q;
		r     = run_q;
		descr = '0;
		for (int i = 0; i < BITS_W; i++) begin
			b = raw.bits[BITS_W-1-i];
			o = b ^ h[first_tap] ^ h[second_tap];
			if (i < 2 || raw.four) begin
				h = {h[HIST_W-2:0], b};
				if (r >= RUN_LIMIT) begin
					o = ~o;
					r = '0;
				end
				r = b ? r + 1'b1 : '0;
				descr[BITS_W-1-i] = o;
			end
		end
		hist_d = h;
		run_d  = r;
	end

	// two-bit items sit in the low bits
	assign data_bits = raw.four ? descr : {2'b00, descr[3:2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q <= '0;
			run_q  <= '0;
		end else if (advance) begin
			hist_q <= hist_d;
			run_q  <= run_d;
		end
	end

endmodule

// File: rtl/core/differential_symbol_descrambler.sv
// top level of the differential symbol descrambler
// One sliced constellation index enters per item. The quadrant change against
// the previous item is mapped to two bits, in sixteen-point mode the two low
// index bits follow, and the two or four bits pass through a two-tap
// self-synchronizing descrambler that also inverts its output after a run of
// 64 raw ones. An accepted item waits in the input register, where decode and
// descramble run as one short combinational pass, until the result register is
// free or draining, and then lands in the result register, which drives
// out_valid. A new item is taken every cycle while the output side keeps
// draining. The result register decouples the two sides, so in_stall only
// rises when the result register is full and stalled and the input register
// is occupied. The user must write the taps through the config port only
// while no item is in flight; the block itself does not enforce this.
module differential_symbol_descrambler (
	input  logic                          clk,
	input  logic                          arst_n,
	// config port
	input  logic                          cfg_write,
	input  logic [dsd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [dsd_pkg::CFG_DATA_W-1:0] cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [dsd_pkg::SYM_W-1:0]     symbol_index,
	input  logic                          sixteen_point,
	input  logic                          deliver,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [dsd_pkg::BITS_W-1:0]    data_bits,
	output logic [dsd_pkg::COUNT_W-1:0]   bit_count,
	output logic                          data_valid
);
	import dsd_pkg::*;

	logic [TAP_W-1:0]  first_tap_q;
	logic [TAP_W-1:0]  second_tap_q;

	// input register
	logic              valid_s1;
	logic [SYM_W-1:0]  sym_s1;
	logic              sixteen_s1;
	logic              deliver_s1;

	logic              in_accept;
	logic              advance;
	raw_t              raw;
	logic [BITS_W-1:0] descr_bits;

	// item leaves the input register when the result register is free or draining
	assign advance   = valid_s1 && (!out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	// tap registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_tap_q  <= FIRST_TAP_RST;
			second_tap_q <= SECOND_TAP_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_FIRST_TAP:  first_tap_q  <= cfg_data[TAP_W-1:0];
				CFG_SECOND_TAP: second_tap_q <= cfg_data[TAP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			sym_s1     <= symbol_index;
			sixteen_s1 <= sixteen_point;
			deliver_s1 <= deliver;
		end
	end

	dsd_decode u_decode (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (advance),
		.symbol_index  (sym_s1),
		.sixteen_point (sixteen_s1),
		.raw           (raw)
	);

	dsd_descrambler u_descrambler (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.first_tap  (first_tap_q),
		.second_tap (second_tap_q),
		.raw        (raw),
		.data_bits  (descr_bits)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_bits  <= descr_bits;
			bit_count  <= sixteen_s1 ? COUNT_FOUR : COUNT_TWO;
			data_valid <= deliver_s1;
		end
	end

endmodule

// File: rtl/core/dsd_checker.sv
// port-level checks for the differential symbol descrambler
module dsd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [3:0] data_bits,
	input logic [2:0] bit_count,
	input logic       data_valid
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_bits)
			&& $stable(bit_count) && $stable(data_valid))
		else $error("stalled result changed");

	// input only backs up behind a full, stalled result register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

	// a two-bit item leaves the upper bits clear
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (bit_count == 3'd4) || (bit_count == 3'd2 && data_bits[3:2] == 2'b00))
		else $error("bad bit count or packing");

	// a fresh result follows an item accepted into the input register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without a matching item");

endmodule

bind differential_symbol_descrambler dsd_checker u_dsd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.data_bits  (data_bits),
	.bit_count  (bit_count),
	.data_valid (data_valid)
);
